[src/rpn_stack_calculator_core_macros.svh]
// ----------------------------------------------------------------------------
// RPN calculator assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_CORE_MACROS_SVH
`define RPN_STACK_CALCULATOR_CORE_MACROS_SVH

// same-cycle implication
`define RPN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RPN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rpn_pkg.sv]
// ----------------------------------------------------------------------------
// RPN calculator package
// Widths, request and status codes, state type and saturation helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int FRAC_BITS   = 16;
    localparam int Q_W         = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int ACC_W       = Q_W + ADDR_W;
    localparam int DIV_W       = Q_W + FRAC_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_W);

    localparam logic signed [63:0] Q_MAX64 = (64'sd1 <<< (Q_W - 1)) - 64'sd1;
    localparam logic signed [63:0] Q_MIN64 = -(64'sd1 <<< (Q_W - 1));
    localparam logic signed [63:0] MUL_RND = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    localparam logic [3:0] REQ_PUSH = 4'd0;
    localparam logic [3:0] REQ_PEEK = 4'd1;
    localparam logic [3:0] REQ_ADD  = 4'd2;
    localparam logic [3:0] REQ_SUB  = 4'd3;
    localparam logic [3:0] REQ_MUL  = 4'd4;
    localparam logic [3:0] REQ_DIV  = 4'd5;
    localparam logic [3:0] REQ_SWAP = 4'd6;
    localparam logic [3:0] REQ_SUM  = 4'd7;
    localparam logic [3:0] REQ_AVG  = 4'd8;
    localparam logic [3:0] REQ_QUIT = 4'd9;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_ONE   = 3'd2;
    localparam logic [2:0] ST_DIV0  = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;
    localparam logic [2:0] ST_FULL  = 3'd5;
    localparam logic [2:0] ST_QUIT  = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_B,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_SUM,
        S_SUM_END,
        S_FIN
    } t_state;

    typedef struct packed {
        logic          flag;
        logic [Q_W-1:0] val;
    } t_sat;

    function automatic t_sat sat_q(input logic signed [63:0] v);
        t_sat s;
        s.flag = 1'b0;
        s.val  = v[Q_W-1:0];
        if (v > Q_MAX64) begin
            s.flag = 1'b1;
            s.val  = Q_MAX64[Q_W-1:0];
        end else if (v < Q_MIN64) begin
            s.flag = 1'b1;
            s.val  = Q_MIN64[Q_W-1:0];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

[src/rpn_div.sv]
// ----------------------------------------------------------------------------
// RPN calculator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpn_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rpn_pkg::DIV_W-1:0]   i_dividend,
    input  logic [rpn_pkg::Q_W-1:0]     i_divisor,
    output logic                        o_done,
    output logic [rpn_pkg::DIV_W-1:0]   o_quotient
);

    logic                            r_busy;
    logic                            r_done;
    logic [rpn_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [rpn_pkg::Q_W:0]           r_rem;
    logic [rpn_pkg::DIV_W-1:0]       r_quo;
    logic [rpn_pkg::Q_W-1:0]         r_dvs;

    logic [rpn_pkg::Q_W:0]           shifted;
    logic [rpn_pkg::Q_W+1:0]         diff;
    logic [rpn_pkg::Q_W:0]           n_rem;
    logic [rpn_pkg::DIV_W-1:0]       n_quo;

    always_comb begin
        shifted = {r_rem[rpn_pkg::Q_W-1:0], r_quo[rpn_pkg::DIV_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        if (!diff[rpn_pkg::Q_W+1]) begin
            n_rem = diff[rpn_pkg::Q_W:0];
            n_quo = {r_quo[rpn_pkg::DIV_W-2:0], 1'b1};
        end else begin
            n_rem = shifted;
            n_quo = {r_quo[rpn_pkg::DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= rpn_pkg::DIV_CNT_W'(rpn_pkg::DIV_W - 1);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

[src/rpn_stack_calculator_core.sv]
// Every request ends with a result strobe. Div and average use the shared iterative divider;
// sum and average walk every stack entry, so their run time grows with the entry count.
// busy stays high until the result strobe, one transaction at a time.
// The result is presented for one cycle and cannot be held off by the receiver.
// Synchronous active-low reset empties the stack; stored entries are not cleared.
// ----------------------------------------------------------------------------
// RPN stack calculator core
// Q16.16 postfix calculator over an operand stack memory with one shared
// multiplier, accumulator and iterative divider under a small sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rpn_stack_calculator_core_macros.svh"

module rpn_stack_calculator_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [3:0]                i_req_type,
    input  logic signed [31:0]        i_push_value,
    output logic                      busy,
    output logic                      o_strobe,
    output logic signed [31:0]        o_result_value,
    output logic [2:0]                o_status
);

    localparam int AW = rpn_pkg::ADDR_W;
    localparam int CW = rpn_pkg::CNT_W;
    localparam int QW = rpn_pkg::Q_W;

    logic signed [QW-1:0]  mem [rpn_pkg::STACK_DEPTH];

    rpn_pkg::t_state       r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic signed [QW-1:0]  r_top, n_top;
    logic [3:0]            r_req, n_req;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic signed [rpn_pkg::ACC_W-1:0] r_acc, n_acc;
    logic signed [63:0]    r_prod, n_prod;
    logic                  r_neg, n_neg;
    logic                  r_wr, n_wr;
    logic [AW-1:0]         r_waddr, n_waddr;
    logic signed [QW-1:0]  r_res, n_res;
    logic [2:0]            r_stat, n_stat;
    logic [CW-1:0]         r_newcount, n_newcount;
    logic                  r_strobe, n_strobe;
    logic signed [QW-1:0]  r_out_val, n_out_val;
    logic [2:0]            r_out_stat, n_out_stat;
    logic signed [QW-1:0]  r_rd_data;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic signed [QW-1:0]  wdata;
    logic [AW-1:0]         rd_addr;

    logic                  div_start;
    logic [rpn_pkg::DIV_W-1:0] div_dividend;
    logic [QW-1:0]         div_divisor;
    logic                  div_done;
    logic [rpn_pkg::DIV_W-1:0] div_quo;

    logic [CW-1:0]         cnt_m1, cnt_m2, idx_m1;
    logic [QW-1:0]         mag_a, mag_b;
    logic [rpn_pkg::ACC_W-1:0] mag_acc;
    logic signed [63:0]    mul_adj, mul_q, div_q;
    rpn_pkg::t_sat         sat_v;

    rpn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign cnt_m1  = r_count - CW'(1);
    assign cnt_m2  = r_count - CW'(2);
    assign idx_m1  = r_idx - CW'(1);
    assign mag_a   = r_top[QW-1] ? (~r_top + 1'b1) : r_top;
    assign mag_b   = r_rd_data[QW-1] ? (~r_rd_data + 1'b1) : r_rd_data;
    assign mag_acc = r_acc[rpn_pkg::ACC_W-1] ? (~r_acc + 1'b1) : r_acc;
    assign mul_adj = r_prod + (r_prod[63] ? rpn_pkg::MUL_RND : 64'sd0);
    assign mul_q   = mul_adj >>> rpn_pkg::FRAC_BITS;
    assign div_q   = r_neg ? -$signed(64'(div_quo)) : $signed(64'(div_quo));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_top        = r_top;
        n_req        = r_req;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_acc        = r_acc;
        n_prod       = r_prod;
        n_neg        = r_neg;
        n_wr         = r_wr;
        n_waddr      = r_waddr;
        n_res        = r_res;
        n_stat       = r_stat;
        n_newcount   = r_newcount;
        n_strobe     = 1'b0;
        n_out_val    = r_out_val;
        n_out_stat   = r_out_stat;
        we           = 1'b0;
        waddr        = '0;
        wdata        = '0;
        rd_addr      = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        sat_v        = '0;

        case (r_state)
            rpn_pkg::S_IDLE: begin
                if (start) begin
                    n_req      = i_req_type;
                    n_stat     = rpn_pkg::ST_OK;
                    n_wr       = 1'b0;
                    n_newcount = r_count;
                    n_res      = (r_count != '0) ? r_top : '0;
                    n_state    = rpn_pkg::S_FIN;
                    case (i_req_type)
                        rpn_pkg::REQ_PUSH: begin
                            if (r_count == CW'(rpn_pkg::STACK_DEPTH)) begin
                                n_stat = rpn_pkg::ST_FULL;
                            end else begin
                                n_res      = i_push_value;
                                n_wr       = 1'b1;
                                n_waddr    = r_count[AW-1:0];
                                n_newcount = r_count + 1'b1;
                            end
                        end
                        rpn_pkg::REQ_PEEK: begin
                            if (r_count == '0) begin
                                n_stat = rpn_pkg::ST_EMPTY;
                            end
                        end
                        rpn_pkg::REQ_ADD, rpn_pkg::REQ_SUB, rpn_pkg::REQ_MUL,
                        rpn_pkg::REQ_DIV, rpn_pkg::REQ_SWAP: begin
                            if (r_count == '0) begin
                                n_stat = rpn_pkg::ST_EMPTY;
                            end else if (r_count == CW'(1)) begin
                                n_stat     = rpn_pkg::ST_ONE;
                                n_res      = '0;
                                n_newcount = '0;
                            end else begin
                                n_state = rpn_pkg::S_RD_B;
                            end
                        end
                        rpn_pkg::REQ_SUM, rpn_pkg::REQ_AVG: begin
                            if (r_count == '0) begin
                                if (i_req_type == rpn_pkg::REQ_AVG) begin
                                    n_stat = rpn_pkg::ST_EMPTY;
                                end else begin
                                    n_wr       = 1'b1;
                                    n_waddr    = '0;
                                    n_res      = '0;
                                    n_newcount = CW'(1);
                                end
                            end else begin
                                n_idx   = r_count;
                                n_acc   = '0;
                                n_pend  = 1'b0;
                                n_state = rpn_pkg::S_SUM;
                            end
                        end
                        rpn_pkg::REQ_QUIT: begin
                            n_stat = rpn_pkg::ST_QUIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            rpn_pkg::S_RD_B: begin
                rd_addr = cnt_m2[AW-1:0];
                n_state = rpn_pkg::S_EXEC;
            end

            rpn_pkg::S_EXEC: begin
                n_newcount = cnt_m1;
                n_wr       = 1'b1;
                n_waddr    = cnt_m2[AW-1:0];
                n_state    = rpn_pkg::S_FIN;
                case (r_req)
                    rpn_pkg::REQ_ADD: begin
                        sat_v  = rpn_pkg::sat_q(64'(r_rd_data) + 64'(r_top));
                        n_res  = sat_v.val;
                        n_stat = sat_v.flag ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK;
                    end
                    rpn_pkg::REQ_SUB: begin
                        sat_v  = rpn_pkg::sat_q(64'(r_rd_data) - 64'(r_top));
                        n_res  = sat_v.val;
                        n_stat = sat_v.flag ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK;
                    end
                    rpn_pkg::REQ_MUL: begin
                        n_prod  = r_top * r_rd_data;
                        n_state = rpn_pkg::S_MUL;
                    end
                    rpn_pkg::REQ_DIV: begin
                        if (r_top == '0) begin
                            n_res  = '0;
                            n_stat = rpn_pkg::ST_DIV0;
                        end else begin
                            div_start    = 1'b1;
                            div_dividend = {mag_b, {rpn_pkg::FRAC_BITS{1'b0}}};
                            div_divisor  = mag_a;
                            n_neg        = r_top[QW-1] ^ r_rd_data[QW-1];
                            n_state      = rpn_pkg::S_DIV;
                        end
                    end
                    rpn_pkg::REQ_SWAP: begin
                        we         = 1'b1;
                        waddr      = cnt_m2[AW-1:0];
                        wdata      = r_top;
                        n_res      = r_rd_data;
                        n_waddr    = cnt_m1[AW-1:0];
                        n_newcount = r_count;
                    end
                    default: begin
                    end
                endcase
            end

            rpn_pkg::S_MUL: begin
                sat_v   = rpn_pkg::sat_q(mul_q);
                n_res   = sat_v.val;
                n_stat  = sat_v.flag ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK;
                n_state = rpn_pkg::S_FIN;
            end

            rpn_pkg::S_DIV: begin
                if (div_done) begin
                    sat_v   = rpn_pkg::sat_q(div_q);
                    n_res   = sat_v.val;
                    n_stat  = (sat_v.flag && r_req == rpn_pkg::REQ_DIV) ?
                              rpn_pkg::ST_SAT : rpn_pkg::ST_OK;
                    n_state = rpn_pkg::S_FIN;
                end
            end

            rpn_pkg::S_SUM: begin
                if (r_idx != '0) begin
                    rd_addr = idx_m1[AW-1:0];
                    n_idx   = idx_m1;
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    n_acc = r_acc + rpn_pkg::ACC_W'(r_rd_data);
                end
                if (r_idx == '0 && !r_pend) begin
                    n_state = rpn_pkg::S_SUM_END;
                end
            end

            rpn_pkg::S_SUM_END: begin
                n_wr       = 1'b1;
                n_waddr    = '0;
                n_newcount = CW'(1);
                if (r_req == rpn_pkg::REQ_SUM) begin
                    sat_v   = rpn_pkg::sat_q(64'(r_acc));
                    n_res   = sat_v.val;
                    n_stat  = sat_v.flag ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK;
                    n_state = rpn_pkg::S_FIN;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = rpn_pkg::DIV_W'(mag_acc);
                    div_divisor  = QW'(r_count);
                    n_neg        = r_acc[rpn_pkg::ACC_W-1];
                    n_state      = rpn_pkg::S_DIV;
                end
            end

            rpn_pkg::S_FIN: begin
                if (r_wr) begin
                    we    = 1'b1;
                    waddr = r_waddr;
                    wdata = r_res;
                end
                n_count    = r_newcount;
                n_top      = r_res;
                n_out_val  = (r_newcount != '0) ? r_res : '0;
                n_out_stat = r_stat;
                n_strobe   = 1'b1;
                n_state    = rpn_pkg::S_IDLE;
            end

            default: begin
                n_state = rpn_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rpn_pkg::S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_req      <= n_req;
        r_idx      <= n_idx;
        r_acc      <= n_acc;
        r_prod     <= n_prod;
        r_neg      <= n_neg;
        r_wr       <= n_wr;
        r_waddr    <= n_waddr;
        r_res      <= n_res;
        r_stat     <= n_stat;
        r_newcount <= n_newcount;
        r_out_val  <= n_out_val;
        r_out_stat <= n_out_stat;
    end

    assign busy           = (r_state != rpn_pkg::S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_result_value = r_out_val;
    assign o_status       = r_out_stat;

    `RPN_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(rpn_pkg::STACK_DEPTH), "stack count beyond depth")
    `RPN_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "accepted transaction did not raise busy")
    `RPN_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "result strobe while busy")
    `RPN_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_strobe && o_status == rpn_pkg::ST_EMPTY, o_result_value == '0, "empty status with non-zero value")

endmodule

`default_nettype wire

[sim/rpn_stack_calculator_core_test.sv]
// ----------------------------------------------------------------------------
// RPN stack calculator core testbench
// Drives request transactions from a queue with random gaps, predicts each
// answer from a local copy of the operand stack and checks every strobed
// result field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_stack_calculator_core_test;

    typedef struct {
        logic [3:0]         req;
        logic signed [31:0] val;
    } t_req;

    typedef struct {
        logic signed [31:0] val;
        logic [2:0]         status;
    } t_answer;

    localparam int unsigned CYCLE_LIMIT = 2000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic [3:0]         i_req_type;
    logic signed [31:0] i_push_value;
    logic               busy;
    logic               o_strobe;
    logic signed [31:0] o_result_value;
    logic [2:0]         o_status;

    t_req    request_queue[$];
    t_answer answer_queue[$];
    logic signed [31:0] model_stack[rpn_pkg::STACK_DEPTH];
    int      model_count = 0;
    int      mismatches = 0;
    int      gap_left;
    int unsigned cycle_count = 0;

    rpn_stack_calculator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_req_type     (i_req_type),
        .i_push_value   (i_push_value),
        .busy           (busy),
        .o_strobe       (o_strobe),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] clamp_q(input logic signed [63:0] v,
                                                   inout logic [2:0] st);
        if (v > 64'sd2147483647) begin
            st = rpn_pkg::ST_SAT;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            st = rpn_pkg::ST_SAT;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic void model_push(input logic signed [31:0] v);
        if (model_count < rpn_pkg::STACK_DEPTH) begin
            model_stack[model_count] = v;
            model_count++;
        end
    endfunction

    function automatic logic signed [31:0] model_pop();
        model_count--;
        return model_stack[model_count];
    endfunction

    function automatic t_answer predict_answer(input t_req r);
        t_answer ans;
        logic [2:0] st;
        logic signed [63:0] a, b, acc, res;
        int n;
        st = rpn_pkg::ST_OK;
        case (r.req)
            rpn_pkg::REQ_PUSH: begin
                if (model_count >= rpn_pkg::STACK_DEPTH) st = rpn_pkg::ST_FULL;
                else model_push(r.val);
            end
            rpn_pkg::REQ_PEEK: if (model_count == 0) st = rpn_pkg::ST_EMPTY;
            rpn_pkg::REQ_ADD, rpn_pkg::REQ_SUB, rpn_pkg::REQ_MUL, rpn_pkg::REQ_DIV,
            rpn_pkg::REQ_SWAP: begin
                if (model_count == 0) begin
                    st = rpn_pkg::ST_EMPTY;
                end else begin
                    a = model_pop();
                    if (model_count == 0) begin
                        st = rpn_pkg::ST_ONE;
                    end else begin
                        b = model_pop();
                        case (r.req)
                            rpn_pkg::REQ_ADD: res = clamp_q(b + a, st);
                            rpn_pkg::REQ_SUB: res = clamp_q(b - a, st);
                            rpn_pkg::REQ_MUL:
                                res = clamp_q((a * b) / (64'sd1 <<< rpn_pkg::FRAC_BITS), st);
                            rpn_pkg::REQ_DIV: begin
                                if (a == 0) begin
                                    st  = rpn_pkg::ST_DIV0;
                                    res = 0;
                                end else begin
                                    res = clamp_q((b * (64'sd1 <<< rpn_pkg::FRAC_BITS)) / a,
                                                  st);
                                end
                            end
                            default: begin
                                model_push(a[31:0]);
                                res = b;
                            end
                        endcase
                        model_push(res[31:0]);
                    end
                end
            end
            rpn_pkg::REQ_SUM: begin
                acc = 0;
                while (model_count > 0) acc += model_pop();
                model_push(clamp_q(acc, st));
            end
            rpn_pkg::REQ_AVG: begin
                if (model_count == 0) begin
                    st = rpn_pkg::ST_EMPTY;
                end else begin
                    acc = 0;
                    n   = model_count;
                    while (model_count > 0) acc += model_pop();
                    res = acc / n;
                    model_push(res[31:0]);
                end
            end
            rpn_pkg::REQ_QUIT: st = rpn_pkg::ST_QUIT;
            default: ;
        endcase
        ans.val    = (model_count > 0) ? model_stack[model_count - 1] : 32'sd0;
        ans.status = st;
        return ans;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic add_request(input logic [3:0] req, input logic signed [31:0] v);
        t_req r;
        r.req = req;
        r.val = v;
        request_queue.push_back(r);
    endtask

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff - $urandom_range(0, 3);
            1: return 32'sh80000000 + $urandom_range(0, 3);
            2: return 0;
            3: return $signed($urandom_range(0, 8)) <<< rpn_pkg::FRAC_BITS;
            4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_req_type   <= rpn_pkg::REQ_PEEK;
            i_push_value <= '0;
            gap_left     <= $urandom_range(0, 6);
        end else if (start && !busy) begin
            start    <= 1'b0;
            gap_left <= $urandom_range(0, 6);
        end else if (!start && !busy && request_queue.size() > 0) begin
            if (request_queue[0].req == 4'hf && request_queue[0].val == 32'sh5a5a5a5a) begin
                // hold until every expected answer is back
                if (answer_queue.size() == 0) void'(request_queue.pop_front());
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else begin
                start        <= 1'b1;
                i_req_type   <= request_queue[0].req;
                i_push_value <= request_queue[0].val;
                answer_queue.push_back(predict_answer(request_queue.pop_front()));
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_answer exp_ans;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_strobe) begin
            if (answer_queue.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                exp_ans = answer_queue.pop_front();
                if (o_result_value !== exp_ans.val)
                    report_mismatch($sformatf("value %h expected %h",
                                              o_result_value, exp_ans.val));
                if (o_status !== exp_ans.status)
                    report_mismatch($sformatf("status %0d expected %0d",
                                              o_status, exp_ans.status));
            end
        end
    end

    initial begin
        int k, kind;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty cases, single-entry pops, extremes, divide by zero
        add_request(rpn_pkg::REQ_PEEK, 0);
        add_request(rpn_pkg::REQ_ADD, 0);
        add_request(rpn_pkg::REQ_AVG, 0);
        add_request(rpn_pkg::REQ_SUM, 0);
        add_request(rpn_pkg::REQ_SWAP, 0);
        add_request(rpn_pkg::REQ_PUSH, 32'sh7fffffff);
        add_request(rpn_pkg::REQ_PUSH, 32'sh7fffffff);
        add_request(rpn_pkg::REQ_ADD, 0);
        add_request(rpn_pkg::REQ_PUSH, 32'sh80000000);
        add_request(rpn_pkg::REQ_PUSH, 32'sh7fffffff);
        add_request(rpn_pkg::REQ_SUB, 0);
        add_request(rpn_pkg::REQ_PUSH, 32'sh80000000);
        add_request(rpn_pkg::REQ_MUL, 0);
        add_request(rpn_pkg::REQ_PUSH, 0);
        add_request(rpn_pkg::REQ_DIV, 0);
        add_request(rpn_pkg::REQ_PUSH, 32'sh00030000);
        add_request(rpn_pkg::REQ_PUSH, 32'shfffe8000);
        add_request(rpn_pkg::REQ_DIV, 0);
        add_request(rpn_pkg::REQ_PUSH, 32'sh7fffffff);
        add_request(rpn_pkg::REQ_SWAP, 0);
        add_request(rpn_pkg::REQ_AVG, 0);
        add_request(rpn_pkg::REQ_QUIT, 0);
        add_request(4'd10, 0);
        add_request(4'd15, 32'sh12345678);
        add_request(rpn_pkg::REQ_PEEK, 0);

        // fill to full and refuse, then sum with overflow
        for (k = 0; k < rpn_pkg::STACK_DEPTH + 2; k++)
            add_request(rpn_pkg::REQ_PUSH, 32'sh7fffffff);
        add_request(4'hf, 32'sh5a5a5a5a);
        add_request(rpn_pkg::REQ_SUM, 0);
        for (k = 0; k < rpn_pkg::STACK_DEPTH; k++)
            add_request(rpn_pkg::REQ_PUSH, 32'sh80000000);
        add_request(rpn_pkg::REQ_AVG, 0);

        // random: pushes and peek or stack operations in equal share, with some noise
        for (k = 0; k < 900; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
                add_request(rpn_pkg::REQ_PUSH, random_value());
            else if (kind < 90)
                add_request(4'($urandom_range(rpn_pkg::REQ_PEEK, rpn_pkg::REQ_SWAP)),
                            $urandom);
            else if (kind < 95)
                add_request(4'($urandom_range(rpn_pkg::REQ_SUM, rpn_pkg::REQ_QUIT)),
                            $urandom);
            else
                add_request(4'($urandom_range(10, 15)), $urandom);
            if (k == 450) add_request(4'hf, 32'sh5a5a5a5a);
        end

        while ((request_queue.size() > 0 || answer_queue.size() > 0 || start)
               && cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout");
            $display("FAIL rpn_stack_calculator_core");
        end else if (mismatches == 0 && answer_queue.size() == 0) begin
            $display("PASS rpn_stack_calculator_core");
        end else begin
            $display("FAIL rpn_stack_calculator_core");
        end
        $finish;
    end

endmodule
